// ----- hw/rtl/trsf_pkg.sv -----
package trsf_pkg;

   // default position width
   localparam int unsigned POSITION_WIDTH = 40;

   // register fields
   localparam int unsigned LIMIT_WIDTH  = 31;
   localparam int unsigned STEP_WIDTH   = 24;
   localparam int unsigned GAIN_WIDTH   = 16;
   localparam int unsigned SPEED_WIDTH  = 32;
   localparam int unsigned CSR_WIDTH    = 32;
   localparam int unsigned CSR_IDX_WIDTH = 3;

   // divider: dividend is |v|^2, divisor is 2*decel
   localparam int unsigned SQ_WIDTH   = 63;
   localparam int unsigned DVS_WIDTH  = STEP_WIDTH + 1;
   localparam int unsigned CNT_WIDTH  = 6;
   localparam int unsigned BRAKE_WIDTH = 64;

   // register indexes
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_LIMIT_POS = 3'd0,
      REG_LIMIT_NEG = 3'd1,
      REG_ACCEL_FWD = 3'd2,
      REG_DECEL_FWD = 3'd3,
      REG_ACCEL_REV = 3'd4,
      REG_DECEL_REV = 3'd5,
      REG_GAINS     = 3'd6,
      REG_WINDOW    = 3'd7
   } csr_index_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic square;
      logic div_step;
      logic brake;
      logic speed;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// ----- hw/rtl/trapezoid_ramp_setpoint_filter_unit.sv -----
// Trapezoidal ramp setpoint filter.
// Input channel req_*: one beat per control tick carrying target position,
// measured position and measured speed. Output channel rsp_*: one beat per
// input beat with the filtered position setpoint and the arrived flag.
// Configuration: csr_we/csr_index/csr_wdata write one of eight registers
// (speed limits, accel/decel steps, anticipation gains, arrival window);
// write only while no tick is in flight.
// Steps from the accepting edge to output valid: square, the
// one-bit-per-cycle divider for v*v/(2*decel), brake sum, speed update,
// output load. The divider sets the rate. One tick is in flight at a time:
// the next input beat is taken only after that output load. A new input
// beat is taken while a finished result still waits in the output register.
// Reset clears the stored speed setpoint, restores register defaults and
// empties the output register. When the receiver stalls, the result holds
// in the output register and the next tick waits before its output load.
module trapezoid_ramp_setpoint_filter_unit #(
   parameter int unsigned POSITION_WIDTH = trsf_pkg::POSITION_WIDTH,
   localparam int unsigned REQ_W = ((2*POSITION_WIDTH + trsf_pkg::SPEED_WIDTH + 7) / 8) * 8,
   localparam int unsigned RSP_W = ((POSITION_WIDTH + 1 + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // target_position, measured_position, measured_speed
   input  logic [REQ_W-1:0]                   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // position_setpoint, arrived
   output logic [RSP_W-1:0]                   rsp_tdata,
   input  logic                               csr_we,
   input  logic [trsf_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [trsf_pkg::CSR_WIDTH-1:0]     csr_wdata
);

   localparam int unsigned PW = POSITION_WIDTH;
   localparam int unsigned VW = trsf_pkg::SPEED_WIDTH;

   trsf_pkg::cmd_type    cmd;
   trsf_pkg::status_type status;
   logic [PW-1:0]        out_position;
   logic                 out_arrived;

   trsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   trsf_datapath #(.PW(PW)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .in_target    (req_tdata[PW-1:0]),
      .in_position  (req_tdata[2*PW-1:PW]),
      .in_speed     (req_tdata[2*PW+VW-1:2*PW]),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .out_position (out_position),
      .out_arrived  (out_arrived)
   );

   // pack result beat, zero fill
   assign rsp_tdata = RSP_W'({out_arrived, out_position});

`ifndef ASSERT_OFF
   // one tick at a time: an accepted beat closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while a tick is in flight");

   // a result is loaded only as its tick finishes
   a_load_at_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("result loaded mid tick");

   // reset leaves the block empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not empty after reset");
`endif

endmodule

// ----- hw/rtl/trsf_ctrl.sv -----
module trsf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  trsf_pkg::status_type status,
   output trsf_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_BRAKE,
      ST_SPEED,
      ST_EMIT
   } state_type;

   state_type state_ff;

   assign req_tready = (state_ff == ST_IDLE);

   // decode commands from state
   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.square   = (state_ff == ST_SQUARE);
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.brake    = (state_ff == ST_BRAKE);
      cmd.speed    = (state_ff == ST_SPEED);
      cmd.emit     = (state_ff == ST_EMIT) && status.out_free;
   end

   // advance through one item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) state_ff <= ST_SQUARE;
            end
            ST_SQUARE: state_ff <= ST_DIVIDE;
            ST_DIVIDE: begin
               if (status.div_last) state_ff <= ST_BRAKE;
            end
            ST_BRAKE: state_ff <= ST_SPEED;
            ST_SPEED: state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (status.out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/trsf_datapath.sv -----
module trsf_datapath #(
   parameter int unsigned PW = trsf_pkg::POSITION_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [trsf_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [trsf_pkg::CSR_WIDTH-1:0]        csr_wdata,
   input  logic [PW-1:0]                         in_target,
   input  logic [PW-1:0]                         in_position,
   input  logic [trsf_pkg::SPEED_WIDTH-1:0]      in_speed,
   input  trsf_pkg::cmd_type                     cmd,
   output trsf_pkg::status_type                  status,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [PW-1:0]                         out_position,
   output logic                                  out_arrived
);

   localparam int unsigned LW = trsf_pkg::LIMIT_WIDTH;
   localparam int unsigned SW = trsf_pkg::STEP_WIDTH;
   localparam int unsigned GW = trsf_pkg::GAIN_WIDTH;
   localparam int unsigned VW = trsf_pkg::SPEED_WIDTH;
   localparam int unsigned QW = trsf_pkg::SQ_WIDTH;
   localparam int unsigned DW = trsf_pkg::DVS_WIDTH;
   localparam int unsigned BW = trsf_pkg::BRAKE_WIDTH;
   localparam int unsigned CW = trsf_pkg::CNT_WIDTH;
   localparam int unsigned AGW = VW + GW;
   // compare width for distance against brake and window
   localparam int unsigned KW = (PW > BW) ? PW : BW;
   // speed sum width and position sum width
   localparam int unsigned XW = VW + 2;
   localparam int unsigned MW = ((PW > VW) ? PW : VW) + 1;

   // configuration registers
   logic [LW-1:0] lim_pos_ff, lim_neg_ff, window_ff;
   logic [SW-1:0] acc_f_ff, dec_f_ff, acc_r_ff, dec_r_ff;
   logic [2*GW-1:0] gains_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_pos_ff <= LW'(1000);
         lim_neg_ff <= LW'(1000);
         acc_f_ff   <= SW'(1);
         dec_f_ff   <= SW'(1);
         acc_r_ff   <= SW'(1);
         dec_r_ff   <= SW'(1);
         gains_ff   <= '0;
         window_ff  <= '0;
      end else if (csr_we) begin
         unique case (trsf_pkg::csr_index_type'(csr_index))
            trsf_pkg::REG_LIMIT_POS: lim_pos_ff <= csr_wdata[LW-1:0];
            trsf_pkg::REG_LIMIT_NEG: lim_neg_ff <= csr_wdata[LW-1:0];
            trsf_pkg::REG_ACCEL_FWD: acc_f_ff   <= csr_wdata[SW-1:0];
            trsf_pkg::REG_DECEL_FWD: dec_f_ff   <= csr_wdata[SW-1:0];
            trsf_pkg::REG_ACCEL_REV: acc_r_ff   <= csr_wdata[SW-1:0];
            trsf_pkg::REG_DECEL_REV: dec_r_ff   <= csr_wdata[SW-1:0];
            trsf_pkg::REG_GAINS:     gains_ff   <= csr_wdata[2*GW-1:0];
            trsf_pkg::REG_WINDOW:    window_ff  <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // capture: direction, distance, speed magnitude, divisor
   logic          fwd_in;
   logic [PW:0]   diff_in;
   logic [PW:0]   ndiff_in;
   logic [VW-1:0] av_in;
   logic [SW-1:0] dec_in;

   logic [PW-1:0] tgt_ff, pos_ff, dist_ff;
   logic          fwd_ff, vneg_ff;
   logic [VW-1:0] av_ff;
   logic [GW-1:0] gain_ff;
   logic [DW-1:0] dvs_ff;

   always_comb begin
      fwd_in   = $signed(in_target) >= $signed(in_position);
      diff_in  = {in_target[PW-1], in_target} - {in_position[PW-1], in_position};
      ndiff_in = (PW+1)'(0) - diff_in;
      av_in    = in_speed[VW-1] ? VW'(0) - in_speed : in_speed;
      dec_in   = fwd_in ? dec_f_ff : dec_r_ff;
      if (dec_in == '0) dec_in = SW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tgt_ff  <= in_target;
         pos_ff  <= in_position;
         fwd_ff  <= fwd_in;
         vneg_ff <= in_speed[VW-1];
         dist_ff <= fwd_in ? diff_in[PW-1:0] : ndiff_in[PW-1:0];
         av_ff   <= av_in;
         gain_ff <= fwd_in ? gains_ff[GW-1:0] : gains_ff[2*GW-1:GW];
         dvs_ff  <= {dec_in, 1'b0};
      end
   end

   // square and gain product, then restoring divide one bit a cycle
   logic [QW-1:0]  quo_ff;
   logic [DW-1:0]  rem_ff;
   logic [CW-1:0]  cnt_ff;
   logic [AGW-1:0] ag_ff;
   logic [2*VW-1:0] sq_in;
   logic [DW+1:0]  trial_in;

   assign sq_in    = av_ff * av_ff;
   assign trial_in = {1'b0, rem_ff, quo_ff[QW-1]} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         quo_ff <= sq_in[QW-1:0];
         rem_ff <= '0;
         cnt_ff <= CW'(QW - 1);
         ag_ff  <= av_ff * gain_ff;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (!trial_in[DW+1]) begin
            rem_ff <= trial_in[DW-1:0];
            quo_ff <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DW-2:0], quo_ff[QW-1]};
            quo_ff <= {quo_ff[QW-2:0], 1'b0};
         end
      end
   end

   assign status.div_last = (cnt_ff == '0);

   // braking distance
   logic [BW-1:0] brake_ff;
   always_ff @(posedge clock) begin
      if (cmd.brake) brake_ff <= BW'(quo_ff) + BW'(ag_ff);
   end

   // speed step, clamp and arrival window
   logic          ahead_in, win_in;
   logic [KW-1:0] dk_in, bk_in;
   logic [SW-1:0] mag_in;
   logic [XW-1:0] sum_in, lo_in, hi_in, clamp_in;
   logic [VW-1:0] speed_ff, spd_ff;
   logic          win_ff;

   always_comb begin
      dk_in = KW'(dist_ff);
      bk_in = KW'(brake_ff);
      if (!vneg_ff) ahead_in = fwd_ff && (dk_in >= bk_in);
      else          ahead_in = fwd_ff || (dk_in <= bk_in);
      if (ahead_in) mag_in = fwd_ff ? acc_f_ff : dec_r_ff;
      else          mag_in = fwd_ff ? dec_f_ff : acc_r_ff;
      sum_in = ahead_in ? {{2{speed_ff[VW-1]}}, speed_ff} + XW'(mag_in)
                        : {{2{speed_ff[VW-1]}}, speed_ff} - XW'(mag_in);
      lo_in  = XW'(0) - XW'(lim_neg_ff);
      hi_in  = XW'(lim_pos_ff);
      priority if ($signed(sum_in) < $signed(lo_in)) clamp_in = lo_in;
      else if ($signed(sum_in) > $signed(hi_in))     clamp_in = hi_in;
      else                                            clamp_in = sum_in;
      win_in = KW'(dist_ff) < KW'(window_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
      end else if (cmd.speed) begin
         speed_ff <= win_in ? VW'(0) : clamp_in[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.speed) begin
         spd_ff <= clamp_in[VW-1:0];
         win_ff <= win_in;
      end
   end

   // saturated position plus speed
   logic [MW-1:0] psum_in, pmax_in, pmin_in, sat_in;
   always_comb begin
      psum_in = MW'($signed(pos_ff)) + MW'($signed(spd_ff));
      pmax_in = MW'({1'b0, {(PW-1){1'b1}}});
      pmin_in = ~pmax_in;
      priority if ($signed(psum_in) > $signed(pmax_in)) sat_in = pmax_in;
      else if ($signed(psum_in) < $signed(pmin_in))     sat_in = pmin_in;
      else                                               sat_in = psum_in;
   end

   // output register, held while the receiver stalls
   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_pos_ff;
   logic          rsp_arr_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pos_ff <= win_ff ? tgt_ff : sat_in[PW-1:0];
         rsp_arr_ff <= win_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign out_position = rsp_pos_ff;
   assign out_arrived  = rsp_arr_ff;

endmodule

// ----- tb/testbench.sv -----
module testbench;

   localparam int unsigned PW    = trsf_pkg::POSITION_WIDTH;
   localparam int unsigned VW    = trsf_pkg::SPEED_WIDTH;
   localparam int unsigned REQ_W = ((2*PW + VW + 7) / 8) * 8;
   localparam int unsigned RSP_W = ((PW + 1 + 7) / 8) * 8;
   localparam int unsigned DRAIN_CYCLES = 90;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam longint PMAX = (64'sd1 <<< (PW - 1)) - 1;
   localparam longint PMIN = -PMAX - 1;

   typedef struct {
      logic [PW-1:0] setpoint;
      logic          arrived;
   } setpoint_beat_type;

   typedef struct {
      logic [PW-1:0]          tgt;
      logic [PW-1:0]          pos;
      logic [VW-1:0]          v;
      bit                     typed;
      logic [PW-1:0]          exp_sp;
      logic                   exp_arr;
   } tick_row_type;

   logic                               clock;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [REQ_W-1:0]                   req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [RSP_W-1:0]                   rsp_tdata;
   logic                               csr_we;
   logic [trsf_pkg::CSR_IDX_WIDTH-1:0] csr_index;
   logic [trsf_pkg::CSR_WIDTH-1:0]     csr_wdata;

   // profile registers mirrored by the predictor
   longint lim_pos, lim_neg, acc_f, dec_f, acc_r, dec_r, gains, window;
   longint speed_sp;

   setpoint_beat_type pending_setpoints[$];
   int unsigned errors;
   int unsigned ticks_sent;
   int unsigned setpoints_seen;
   int unsigned arrivals_seen;
   int unsigned idle_cycles;
   bit          idling_on;

   trapezoid_ramp_setpoint_filter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // advance the ramp by one tick and return the setpoint it yields
   function automatic setpoint_beat_type ramp_tick(logic [PW-1:0] tgt_bits,
                                                   logic [PW-1:0] pos_bits,
                                                   logic [VW-1:0] v_bits);
      longint tgt, pos, v, remaining, av, dec, gain, brake, step, spd, res;
      bit fwd, ahead;
      setpoint_beat_type beat;
      tgt = $signed(tgt_bits);
      pos = $signed(pos_bits);
      v = $signed(v_bits);
      fwd = tgt >= pos;
      remaining = fwd ? tgt - pos : pos - tgt;
      av = v < 0 ? -v : v;
      dec = fwd ? dec_f : dec_r;
      gain = fwd ? (gains & 'hFFFF) : ((gains >> 16) & 'hFFFF);
      // a zero decel only matters to the braking divisor
      if (dec == 0) dec = 1;
      brake = (av * av) / (2 * dec) + av * gain;
      if (v >= 0) ahead = fwd && remaining >= brake;
      else        ahead = fwd || remaining <= brake;
      if (ahead) step = fwd ? acc_f : dec_r;
      else       step = -(fwd ? dec_f : acc_r);
      spd = speed_sp + step;
      if (spd < -lim_neg)     spd = -lim_neg;
      else if (spd > lim_pos) spd = lim_pos;
      speed_sp = spd;
      if (remaining < window) begin
         speed_sp = 0;
         beat.setpoint = tgt_bits;
         beat.arrived = 1'b1;
      end else begin
         res = pos + spd;
         if (res > PMAX) res = PMAX;
         if (res < PMIN) res = PMIN;
         beat.setpoint = res[PW-1:0];
         beat.arrived = 1'b0;
      end
      return beat;
   endfunction

   task automatic csr_write(trsf_pkg::csr_index_type idx, longint value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[trsf_pkg::CSR_WIDTH-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         trsf_pkg::REG_LIMIT_POS: lim_pos = value & 'h7FFF_FFFF;
         trsf_pkg::REG_LIMIT_NEG: lim_neg = value & 'h7FFF_FFFF;
         trsf_pkg::REG_ACCEL_FWD: acc_f = value & 'hFF_FFFF;
         trsf_pkg::REG_DECEL_FWD: dec_f = value & 'hFF_FFFF;
         trsf_pkg::REG_ACCEL_REV: acc_r = value & 'hFF_FFFF;
         trsf_pkg::REG_DECEL_REV: dec_r = value & 'hFF_FFFF;
         trsf_pkg::REG_GAINS:     gains = value & 'hFFFF_FFFF;
         trsf_pkg::REG_WINDOW:    window = value & 'h7FFF_FFFF;
         default: ;
      endcase
   endtask

   // wait for the pipe to empty, then load a whole profile
   task automatic load_profile(longint lp, longint ln, longint af, longint df,
                               longint ar, longint dr, longint g, longint w);
      wait (pending_setpoints.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(trsf_pkg::REG_LIMIT_POS, lp);
      csr_write(trsf_pkg::REG_LIMIT_NEG, ln);
      csr_write(trsf_pkg::REG_ACCEL_FWD, af);
      csr_write(trsf_pkg::REG_DECEL_FWD, df);
      csr_write(trsf_pkg::REG_ACCEL_REV, ar);
      csr_write(trsf_pkg::REG_DECEL_REV, dr);
      csr_write(trsf_pkg::REG_GAINS, g);
      csr_write(trsf_pkg::REG_WINDOW, w);
   endtask

   // offer one tick beat and hold it until taken
   task automatic send_tick(logic [PW-1:0] tgt, logic [PW-1:0] pos,
                            logic [VW-1:0] v, bit typed,
                            setpoint_beat_type typed_beat);
      setpoint_beat_type beat;
      @(negedge clock);
      while (idling_on && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {v, pos, tgt};
      do @(posedge clock); while (!req_tready);
      beat = ramp_tick(tgt, pos, v);
      pending_setpoints.push_back(typed ? typed_beat : beat);
      ticks_sent++;
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // mostly ticks of a move closing in on a target, some raw noise
   task automatic send_random_tick();
      logic [PW-1:0] tgt, pos;
      logic [VW-1:0] v;
      longint off;
      setpoint_beat_type none;
      none = '{default: '0};
      if ($urandom_range(99) < 20) begin
         tgt = PW'({$urandom, $urandom});
         pos = PW'({$urandom, $urandom});
         v = $urandom;
      end else begin
         tgt = PW'({$urandom_range(255), $urandom});
         off = longint'($urandom_range(40000)) - 20000;
         if ($urandom_range(3) == 0) off = off * 1000;
         pos = tgt + off[PW-1:0];
         off = longint'($urandom_range(6000)) - 3000;
         v = off[VW-1:0];
      end
      send_tick(tgt, pos, v, 1'b0, none);
   endtask

   // receiver: random stalls, drive at the falling edge
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !(idling_on && $urandom_range(99) < 6);
   end

   // compare each setpoint beat with the oldest expectation
   always @(posedge clock) begin
      setpoint_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         setpoints_seen++;
         if (rsp_tdata[PW]) arrivals_seen++;
         if (pending_setpoints.size() == 0) begin
            errors++;
            $display("%0t: unexpected setpoint beat %h", $time, rsp_tdata);
         end else begin
            want = pending_setpoints.pop_front();
            if (rsp_tdata[PW-1:0] !== want.setpoint) begin
               errors++;
               $display("%0t: setpoint expected %h actual %h", $time,
                        want.setpoint, rsp_tdata[PW-1:0]);
            end
            if (rsp_tdata[PW] !== want.arrived) begin
               errors++;
               $display("%0t: arrived expected %b actual %b", $time,
                        want.arrived, rsp_tdata[PW]);
            end
         end
      end
   end

   // watchdog on beats of either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   tick_row_type directed_rows[] = '{
      // at reset: one forward accel step from rest
      '{40'h0, 40'h0, 32'h0, 1'b1, 40'h1, 1'b0},
      '{40'h7F_FFFF_FFFF, 40'h80_0000_0000, 32'h7FFF_FFFF, 1'b0, '0, 1'b0},
      '{40'h80_0000_0000, 40'h7F_FFFF_FFFF, 32'h8000_0000, 1'b0, '0, 1'b0},
      '{40'h7F_FFFF_FFFF, 40'h7F_FFFF_FFFF, 32'h0, 1'b0, '0, 1'b0},
      '{40'h80_0000_0000, 40'h80_0000_0000, 32'hFFFF_FFFF, 1'b0, '0, 1'b0},
      '{40'h1000, 40'h0, 32'd10, 1'b0, '0, 1'b0},
      '{40'h1000, 40'h0FFF, 32'd200, 1'b0, '0, 1'b0},
      '{40'h0, 40'h1000, 32'hFFFF_FF00, 1'b0, '0, 1'b0},
      '{40'h0, 40'h10, 32'hFFFF_FFF0, 1'b0, '0, 1'b0},
      '{40'h0, 40'h10, 32'd16, 1'b0, '0, 1'b0},
      '{40'h10, 40'h0, 32'hFFFF_FFF0, 1'b0, '0, 1'b0},
      '{40'hFF_FFFF_FFFF, 40'h0, 32'h5555_5555, 1'b0, '0, 1'b0},
      '{40'h55_5555_5555, 40'hAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b0, '0, 1'b0}
   };

   initial begin
      setpoint_beat_type typed_beat;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      ticks_sent = 0;
      setpoints_seen = 0;
      arrivals_seen = 0;
      idle_cycles = 0;
      idling_on = 1'b1;
      lim_pos = 1000; lim_neg = 1000;
      acc_f = 1; dec_f = 1; acc_r = 1; dec_r = 1;
      gains = 0; window = 0;
      speed_sp = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table under reset defaults
      foreach (directed_rows[i]) begin
         typed_beat.setpoint = directed_rows[i].exp_sp;
         typed_beat.arrived = directed_rows[i].exp_arr;
         send_tick(directed_rows[i].tgt, directed_rows[i].pos, directed_rows[i].v,
                   directed_rows[i].typed, typed_beat);
      end
      repeat (180) send_random_tick();

      for (int phase = 1; phase < 7; phase++) begin
         case (phase)
            1: load_profile('h7FFF_FFFF, 'h7FFF_FFFF, 'hFF_FFFF, 'hFF_FFFF,
                            'hFF_FFFF, 'hFF_FFFF, 'hFFFF_FFFF, 'h7FFF_FFFF);
            // zero braking divisor and zero limits
            2: load_profile(0, 0, 1, 0, 1, 0, 0, 0);
            3: load_profile(5000, 4000, 20, 30, 25, 15, 'h0003_0002, 50);
            default: load_profile($urandom_range(20000), $urandom_range(20000),
                                  $urandom_range(500), $urandom_range(500),
                                  $urandom_range(500), $urandom_range(500),
                                  $urandom, $urandom_range(3000));
         endcase
         idling_on = (phase != 3);
         for (int n = 0; n < 200; n++) begin
            // hold off until the pipe has drained once
            if (phase == 5 && n == 100) wait (pending_setpoints.size() == 0);
            send_random_tick();
         end
      end

      idling_on = 1'b1;
      wait (pending_setpoints.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d ticks over seven register profiles; %0d setpoints checked,",
               ticks_sent, setpoints_seen);
      $display("%0d of them inside the arrival window.", arrivals_seen);
      if (errors == 0 && pending_setpoints.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
